>>> design/sbch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbch_pkg: shared definitions for the segment/box closest-hit block
// Default widths and request codes.
// ----------------------------------------------------------------------------
package sbch_pkg;

  localparam int unsigned CoordWidthDef    = 32;
  localparam int unsigned ParamFracBitsDef = 30;

  // Coordinates carry this many fraction bits
  localparam int unsigned CoordFracBits = 16;

  localparam logic REQ_SEGMENT = 1'b0;
  localparam logic REQ_BOX     = 1'b1;

endpackage

>>> design/segment_box_closest_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_closest_hit: nearest hit of a 3D segment against a box stream
//
// Input channel (in_valid_i / in_ready_o) takes one transaction per item.
// A segment transaction (req_type_i = 0) stores start a and delta b - a and
// clears the best hit. A box transaction (req_type_i = 1, a = min, b = max)
// runs the slab test on x, y and z; the box with the strictly smallest entry
// parameter is kept. A transaction with last_i set produces one result on the
// output channel (out_valid_o / out_ready_i): hit flag and nearest point, the
// point zero when nothing was hit; the best hit is then cleared.
// A box runs the slab test on each axis in turn (each non-parallel axis runs
// two divisions through one restoring divider, one quotient bit a cycle; a
// parallel axis needs no division, a miss stops early) and, when it becomes
// the best hit, computes the point through one shift-add multiplier.
// The block holds in_ready_o low while it works and while a result waits;
// a stalled receiver simply keeps it in that state. Reset clears the segment
// to all zero and the best hit.
// ----------------------------------------------------------------------------
module segment_box_closest_hit
  import sbch_pkg::*;
#(
  parameter int unsigned COORD_WIDTH     = CoordWidthDef,
  parameter int unsigned PARAM_FRAC_BITS = ParamFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic signed [COORD_WIDTH-1:0] a_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_z_i,
  input  logic signed [COORD_WIDTH-1:0] b_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_z_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_y_o,
  output logic signed [COORD_WIDTH-1:0] hit_z_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned F     = PARAM_FRAC_BITS;
  localparam int unsigned DW    = CW + 1;      // delta and numerator
  localparam int unsigned PW    = F + 2;       // slab parameter
  localparam int unsigned RW    = CW + 2;      // divider remainder
  localparam int unsigned AW    = CW + F + 1;  // multiplier accumulator
  localparam int unsigned CNT_W = $clog2(F + 2);

  localparam logic signed [PW-1:0] T_ONE   = PW'(1) << F;
  localparam logic        [PW-1:0] SAT_NEG = PW'(1) << (F + 1);
  localparam logic        [PW-1:0] SAT_POS = (PW'(1) << (F + 1)) - PW'(1);
  localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(F);

  typedef enum logic [3:0] {
    ST_IDLE, ST_AXIS, ST_DIV, ST_DIVEND, ST_DECIDE, ST_MUL, ST_POINT,
    ST_FINISH, ST_OUT
  } state_e;

  state_e state_q;

  logic signed [CW-1:0] start_q [3];
  logic signed [DW-1:0] delta_q [3];
  logic signed [CW-1:0] a_q [3];
  logic signed [CW-1:0] b_q [3];
  logic                 last_q;
  logic                 found_q;
  logic signed [PW-1:0] best_q;
  logic signed [CW-1:0] best_pt_q [3];
  logic [1:0]           ax_q;
  logic                 sub_q;
  logic signed [PW-1:0] tmin_q, tmax_q, t1_q;
  logic [RW-1:0]        rem_q;
  logic [PW-1:0]        quo_q;
  logic [DW-1:0]        dmag_q;
  logic                 neg_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [AW-1:0]        acc_q;
  logic [F:0]           mq_q;
  logic                 out_valid_q, hit_q;
  logic signed [CW-1:0] hit_pt_q [3];

  // Axis datapath
  logic signed [CW-1:0] s_ax, lim;
  logic signed [DW-1:0] d_ax, num;
  logic [DW-1:0]        n_mag, d_mag;
  logic                 par_miss;
  logic [RW-1:0]        shifted, d_ext;
  logic                 sub_ok;
  logic signed [PW-1:0] res, lo, hi, ntmin, ntmax;
  logic [AW-1:0]        acc_next;
  logic [DW-1:0]        prod;
  logic signed [RW-1:0] pt_wide;

  function automatic logic [DW-1:0] d_mag_next(input logic signed [DW-1:0] d);
    d_mag_next = d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  always_comb begin
    s_ax     = start_q[ax_q];
    d_ax     = delta_q[ax_q];
    lim      = sub_q ? b_q[ax_q] : a_q[ax_q];
    par_miss = (s_ax < a_q[ax_q]) || (s_ax > b_q[ax_q]);
    num      = DW'(lim) - DW'(s_ax);
    n_mag    = num[DW-1] ? DW'(-num) : DW'(num);
    d_mag    = d_ax[DW-1] ? DW'(-d_ax) : DW'(d_ax);
    // Restoring divider step: first step takes the integer bit unshifted
    shifted  = (cnt_q == '0) ? rem_q : {rem_q[RW-2:0], 1'b0};
    d_ext    = RW'(dmag_q);
    sub_ok   = shifted >= d_ext;
    res      = neg_q ? -$signed(quo_q) : $signed(quo_q);
    lo       = (t1_q > res) ? res : t1_q;
    hi       = (t1_q > res) ? t1_q : res;
    ntmin    = (lo > tmin_q) ? lo : tmin_q;
    ntmax    = (hi < tmax_q) ? hi : tmax_q;
    // Shift-add multiplier, tmin bits taken MSB first
    acc_next = {acc_q[AW-2:0], 1'b0} + (mq_q[F] ? AW'(dmag_q) : '0);
    prod     = acc_q[AW-1:F];
    pt_wide  = neg_q ? (RW'(s_ax) - $signed(RW'(prod)))
                     : (RW'(s_ax) + $signed(RW'(prod)));
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign hit_x_o     = hit_pt_q[0];
  assign hit_y_o     = hit_pt_q[1];
  assign hit_z_o     = hit_pt_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      found_q     <= 1'b0;
      best_q      <= '0;
      ax_q        <= '0;
      sub_q       <= 1'b0;
      tmin_q      <= '0;
      tmax_q      <= '0;
      t1_q        <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      dmag_q      <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      acc_q       <= '0;
      mq_q        <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        start_q[i]   <= '0;
        delta_q[i]   <= '0;
        a_q[i]       <= '0;
        b_q[i]       <= '0;
        best_pt_q[i] <= '0;
        hit_pt_q[i]  <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            a_q[0] <= a_x_i; a_q[1] <= a_y_i; a_q[2] <= a_z_i;
            b_q[0] <= b_x_i; b_q[1] <= b_y_i; b_q[2] <= b_z_i;
            last_q <= last_i;
            ax_q   <= '0;
            sub_q  <= 1'b0;
            tmin_q <= '0;
            tmax_q <= T_ONE;
            if (req_type_i == REQ_SEGMENT) begin
              start_q[0] <= a_x_i; start_q[1] <= a_y_i; start_q[2] <= a_z_i;
              delta_q[0] <= DW'(b_x_i) - DW'(a_x_i);
              delta_q[1] <= DW'(b_y_i) - DW'(a_y_i);
              delta_q[2] <= DW'(b_z_i) - DW'(a_z_i);
              found_q <= 1'b0;
              best_q  <= '0;
              for (int i = 0; i < 3; i++) best_pt_q[i] <= '0;
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_AXIS;
            end
          end
        end
        ST_AXIS: begin
          if (d_ax == '0) begin
            // Parallel axis: inside the slab or a miss
            if (par_miss) state_q <= ST_FINISH;
            else if (ax_q == 2'd2) state_q <= ST_DECIDE;
            else ax_q <= ax_q + 2'd1;
          end else begin
            dmag_q <= d_mag;
            neg_q  <= num[DW-1] ^ d_ax[DW-1];
            cnt_q  <= '0;
            if (RW'(n_mag) >= {d_mag, 1'b0}) begin
              quo_q   <= (num[DW-1] ^ d_ax[DW-1]) ? SAT_NEG : SAT_POS;
              state_q <= ST_DIVEND;
            end else begin
              rem_q   <= RW'(n_mag);
              quo_q   <= '0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem_q <= sub_ok ? shifted - d_ext : shifted;
          quo_q <= {quo_q[PW-2:0], sub_ok};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) state_q <= ST_DIVEND;
        end
        ST_DIVEND: begin
          if (!sub_q) begin
            t1_q    <= res;
            sub_q   <= 1'b1;
            state_q <= ST_AXIS;
          end else begin
            tmin_q <= ntmin;
            tmax_q <= ntmax;
            sub_q  <= 1'b0;
            if (ntmin > ntmax) state_q <= ST_FINISH;
            else if (ax_q == 2'd2) state_q <= ST_DECIDE;
            else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= ST_AXIS;
            end
          end
        end
        ST_DECIDE: begin
          // Equal entry keeps the earlier box
          if (found_q && (tmin_q >= best_q)) begin
            state_q <= ST_FINISH;
          end else begin
            found_q <= 1'b1;
            best_q  <= tmin_q;
            ax_q    <= '0;
            acc_q   <= '0;
            mq_q    <= tmin_q[F:0];
            cnt_q   <= '0;
            dmag_q  <= DW'(delta_q[0][DW-1] ? -delta_q[0] : delta_q[0]);
            neg_q   <= delta_q[0][DW-1];
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_q <= acc_next;
          mq_q  <= {mq_q[F-1:0], 1'b0};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) state_q <= ST_POINT;
        end
        ST_POINT: begin
          best_pt_q[ax_q] <= pt_wide[CW-1:0];
          if (ax_q == 2'd2) begin
            state_q <= ST_FINISH;
          end else begin
            ax_q    <= ax_q + 2'd1;
            acc_q   <= '0;
            mq_q    <= tmin_q[F:0];
            cnt_q   <= '0;
            dmag_q  <= d_mag_next(delta_q[ax_q + 2'd1]);
            neg_q   <= delta_q[ax_q + 2'd1][DW-1];
            state_q <= ST_MUL;
          end
        end
        ST_FINISH: begin
          if (last_q) begin
            // Emit, then clear the best hit for the next cast
            out_valid_q <= 1'b1;
            hit_q       <= found_q;
            for (int i = 0; i < 3; i++) begin
              hit_pt_q[i]  <= best_pt_q[i];
              best_pt_q[i] <= '0;
            end
            found_q <= 1'b0;
            best_q  <= '0;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while a result waits");
  a_nohit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (hit_x_o == '0 && hit_y_o == '0 && hit_z_o == '0))
    else $error("miss result carries a nonzero point");
  a_best_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (best_pt_q[0] == '0 && best_pt_q[1] == '0 && best_pt_q[2] == '0))
    else $error("best point set without a hit");
  a_tmin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> (tmin_q >= 0 && tmin_q <= T_ONE))
    else $error("entry parameter outside the segment");
`endif

endmodule

>>> sim/segment_box_closest_hit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_closest_hit_tb: self-checking bench for the closest-hit block
// Streams segments and boxes through the input channel. A bit-accurate slab
// predictor builds each expected result, and every output transaction is
// checked against it in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module segment_box_closest_hit_tb;
  import sbch_pkg::*;

  localparam int unsigned FracBits = ParamFracBitsDef;
  localparam longint      ParamOne = longint'(1) << FracBits;
  localparam longint      ParamSat = longint'(1) << (FracBits + 1);

  typedef struct packed {
    logic        hit;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } hit_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = REQ_SEGMENT;
  logic signed [31:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [31:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        hit_o;
  logic signed [31:0] hit_x_o, hit_y_o, hit_z_o;

  // Predictor state
  longint   seg_org [3];
  longint   seg_dir [3];
  bit       hit_seen;
  longint   near_t;
  longint   near_pt [3];
  hit_res_t hit_queue [$];

  int n_items, n_casts, n_results, n_hits, n_errors;
  int hold_cycles;

  always #5 clk_i = ~clk_i;

  segment_box_closest_hit dut (.*);

  function automatic longint unsigned mag(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Sign-magnitude quotient, truncated and saturated
  function automatic longint slab_div(input longint num, input longint den);
    longint unsigned n, d, ip, rem, q;
    bit neg;
    n   = mag(num);
    d   = mag(den);
    neg = (num < 0) != (den < 0);
    ip  = n / d;
    rem = n % d;
    if (ip >= 2) return neg ? -ParamSat : ParamSat - 1;
    q = ip;
    for (int i = 0; i < FracBits; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q   = q | 1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic void clear_near();
    hit_seen = 0;
    near_t   = 0;
    foreach (near_pt[i]) near_pt[i] = 0;
  endfunction

  function automatic void slab_box(input longint lo [3], input longint hi [3]);
    longint t_in, t_out, t1, t2, tmp;
    longint unsigned p;
    t_in  = 0;
    t_out = ParamOne;
    for (int ax = 0; ax < 3; ax++) begin
      if (seg_dir[ax] == 0) begin
        if (seg_org[ax] < lo[ax] || seg_org[ax] > hi[ax]) return;
      end else begin
        t1 = slab_div(lo[ax] - seg_org[ax], seg_dir[ax]);
        t2 = slab_div(hi[ax] - seg_org[ax], seg_dir[ax]);
        if (t1 > t2) begin
          tmp = t1; t1 = t2; t2 = tmp;
        end
        if (t1 > t_in) t_in = t1;
        if (t2 < t_out) t_out = t2;
        if (t_in > t_out) return;
      end
    end
    // Keep the earlier box on a tie
    if (hit_seen && t_in >= near_t) return;
    hit_seen = 1;
    near_t   = t_in;
    for (int ax = 0; ax < 3; ax++) begin
      p = (mag(seg_dir[ax]) * longint'(t_in)) >> FracBits;
      near_pt[ax] = seg_org[ax] + ((seg_dir[ax] < 0) ? -longint'(p) : longint'(p));
    end
  endfunction

  // Advance the predictor by one accepted transaction
  function automatic void predict_hit(input logic rt, input int a [3], input int b [3],
                                      input logic lst);
    longint lo [3], hi [3];
    hit_res_t r;
    foreach (lo[i]) begin
      lo[i] = a[i];
      hi[i] = b[i];
    end
    if (rt == REQ_SEGMENT) begin
      foreach (lo[i]) begin
        seg_org[i] = lo[i];
        seg_dir[i] = hi[i] - lo[i];
      end
      clear_near();
      n_casts++;
    end else begin
      slab_box(lo, hi);
    end
    if (lst) begin
      r.hit = hit_seen;
      r.x   = hit_seen ? near_pt[0][31:0] : '0;
      r.y   = hit_seen ? near_pt[1][31:0] : '0;
      r.z   = hit_seen ? near_pt[2][31:0] : '0;
      hit_queue.push_back(r);
      if (hit_seen) n_hits++;
      clear_near();
    end
  endfunction

  task automatic report_err(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("ERROR %0t: result %0d %s got %h expected %h", $time, n_results, what, got, exp);
    n_errors++;
  endtask

  // Send one transaction; valid stays high across back-to-back items
  task automatic send_item(input logic rt, input int a [3], input int b [3], input logic lst);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= rt;
    a_x_i <= a[0]; a_y_i <= a[1]; a_z_i <= a[2];
    b_x_i <= b[0]; b_y_i <= b[1]; b_z_i <= b[2];
    last_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    predict_hit(rt, a, b, lst);
    n_items++;
  endtask

  // Receiver: random stalls, one long hold on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (hit_queue.size() == 0) begin
        $display("ERROR %0t: result with nothing expected", $time);
        n_errors++;
      end else begin
        hit_res_t e;
        e = hit_queue.pop_front();
        if (hit_o !== e.hit) report_err("hit", 32'(hit_o), 32'(e.hit));
        if (hit_x_o !== e.x) report_err("x", hit_x_o, e.x);
        if (hit_y_o !== e.y) report_err("y", hit_y_o, e.y);
        if (hit_z_o !== e.z) report_err("z", hit_z_o, e.z);
      end
      n_results++;
    end
  end

  function automatic int small_coord();
    return int'($urandom_range(0, 1310720)) - 655360;
  endfunction

  function automatic int any_coord();
    return ($urandom_range(0, 7) == 0) ? int'($urandom) : small_coord();
  endfunction

  task automatic test_directed();
    int z3 [3], mx [3], mn [3], a [3], b [3];
    z3 = '{0, 0, 0};
    mx = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
    mn = '{32'h80000000, 32'h80000000, 32'h80000000};
    // Box before any segment: zero segment sits inside a box spanning the origin
    send_item(REQ_BOX, '{-65536, -65536, -65536}, '{65536, 65536, 65536}, 1'b1);
    // Last on a segment item
    send_item(REQ_SEGMENT, mn, mx, 1'b1);
    // Widest delta against the full box and an inverted box
    send_item(REQ_BOX, mn, mx, 1'b0);
    send_item(REQ_BOX, mx, mn, 1'b1);
    // Reverse direction, tiny and huge boxes
    send_item(REQ_SEGMENT, mx, mn, 1'b0);
    send_item(REQ_BOX, '{-1, -1, -1}, '{1, 1, 1}, 1'b0);
    send_item(REQ_BOX, '{100, 100, 100}, '{200, 200, 200}, 1'b1);
    // Parallel in x and y: inside, outside, inverted
    send_item(REQ_SEGMENT, '{65536, 65536, 0}, '{65536, 65536, 655360}, 1'b0);
    send_item(REQ_BOX, '{0, 0, 131072}, '{131072, 131072, 196608}, 1'b0);
    send_item(REQ_BOX, '{131072, 0, 0}, '{196608, 131072, 65536}, 1'b0);
    send_item(REQ_BOX, '{131072, 0, 0}, '{0, 131072, 65536}, 1'b1);
    // Boxes after an emit reuse the segment; equal entries keep the earlier box
    a = '{0, 0, 65536};  b = '{131072, 65536, 131072};
    send_item(REQ_BOX, a, b, 1'b0);
    a = '{65536, 0, 65536}; b = '{131072, 131072, 262144};
    send_item(REQ_BOX, a, b, 1'b0);
    send_item(REQ_BOX, '{0, 0, 0}, '{131072, 131072, 32768}, 1'b1);
    // Saturating quotients: huge box over a one-lsb delta
    send_item(REQ_SEGMENT, z3, '{1, 1, 1}, 1'b0);
    send_item(REQ_BOX, mn, mx, 1'b0);
    send_item(REQ_BOX, '{32'h7ffffff0, 0, 0}, mx, 1'b1);
    // Segment entirely inside the box, then one missing on every axis
    send_item(REQ_SEGMENT, '{-5, 7, 9}, '{11, -3, 4}, 1'b0);
    send_item(REQ_BOX, '{-100, -100, -100}, '{100, 100, 100}, 1'b0);
    mn = '{200, 200, 200}; mx = '{300, 300, 300};
    send_item(REQ_BOX, mn, mx, 1'b1);
  endtask

  task automatic random_cast(input int n_boxes);
    int s [3], e [3], lo [3], hi [3];
    foreach (s[i]) begin
      s[i] = any_coord();
      e[i] = ($urandom_range(0, 5) == 0) ? s[i] : any_coord();
    end
    send_item(REQ_SEGMENT, s, e, n_boxes == 0);
    for (int k = 0; k < n_boxes; k++) begin
      foreach (lo[i]) begin
        lo[i] = any_coord();
        hi[i] = ($urandom_range(0, 9) == 0) ? any_coord() :
                lo[i] + int'($urandom_range(0, 400000));
        if ($urandom_range(0, 9) == 0) lo[i] = s[i];
      end
      send_item(REQ_BOX, lo, hi, k == n_boxes - 1);
    end
  endtask

  task automatic test_random();
    while (n_items < 650) begin
      if ($urandom_range(0, 15) == 0) begin
        int lo [3], hi [3];
        // Noise: loose boxes continuing the previous segment
        foreach (lo[i]) begin
          lo[i] = int'($urandom);
          hi[i] = int'($urandom);
        end
        send_item(REQ_BOX, lo, hi, 1'($urandom_range(0, 1)));
      end else begin
        random_cast($urandom_range(0, 6));
      end
    end
  endtask

  // Long receiver hold while casts keep coming, so the input stalls
  task automatic test_backpressure();
    hold_cycles = 2000;
    repeat (6) random_cast($urandom_range(0, 2));
  endtask

  initial begin
    n_items = 0; n_casts = 0; n_results = 0; n_hits = 0; n_errors = 0;
    hold_cycles = 0;
    clear_near();
    foreach (seg_org[i]) begin
      seg_org[i] = 0;
      seg_dir[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random();
    in_valid_i <= 1'b0;
    while (hit_queue.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Covered %0d transactions in %0d casts, %0d results checked (%0d hits).",
             n_items, n_casts, n_results, n_hits);
    if (n_errors == 0) begin
      $display("segment_box_closest_hit verification clean");
    end else begin
      $display("segment_box_closest_hit verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TIMEOUT: stimulus or results did not drain");
    $display("segment_box_closest_hit verification failed");
    $finish;
  end

endmodule

>>> filelist.f
design/sbch_pkg.sv
design/segment_box_closest_hit.sv
sim/segment_box_closest_hit_tb.sv
